### rtl/iea_pkg.sv
// ----------------------------------------------------------------------------
// iea_pkg
// Shared types, codes and defaults for the indexed element array engine.
// ----------------------------------------------------------------------------
package iea_pkg;

  // Port widths fixed by the transaction format
  localparam int OPCODE_W    = 3;
  localparam int POSITION_W  = 8;
  localparam int ELEM_PORT_W = 64;
  localparam int STATUS_W    = 2;
  localparam int LENGTH_W    = 9;

  // Defaults for the top-level parameters
  localparam int DEF_CAPACITY      = 256;
  localparam int DEF_ELEMENT_WIDTH = 64;

  typedef logic [OPCODE_W-1:0]    opcode_t;
  typedef logic [POSITION_W-1:0]  position_t;
  typedef logic [ELEM_PORT_W-1:0] elem_port_t;
  typedef logic [STATUS_W-1:0]    status_t;
  typedef logic [LENGTH_W-1:0]    length_t;

  // Operation codes
  localparam opcode_t OP_PUSH   = 3'd0;
  localparam opcode_t OP_POP    = 3'd1;
  localparam opcode_t OP_GET    = 3'd2;
  localparam opcode_t OP_SET    = 3'd3;
  localparam opcode_t OP_INSERT = 3'd4;
  localparam opcode_t OP_REMOVE = 3'd5;

  // Result status codes
  localparam status_t ST_OK     = 2'd0;
  localparam status_t ST_BOUNDS = 2'd1;
  localparam status_t ST_FULL   = 2'd2;

endpackage

### rtl/iea_store.sv
// ----------------------------------------------------------------------------
// iea_store
// Element memory: one write port, one read port, registered read data.
// ----------------------------------------------------------------------------
module iea_store #(
  parameter int DEPTH  = 256,
  parameter int ADDR_W = 8,
  parameter int DATA_W = 64
) (
  input  logic              clk,
  input  logic              wr_en,
  input  logic [ADDR_W-1:0] wr_addr,
  input  logic [DATA_W-1:0] wr_data,
  input  logic              rd_en,
  input  logic [ADDR_W-1:0] rd_addr,
  output logic [DATA_W-1:0] rd_data
);

  logic [DATA_W-1:0] mem [DEPTH];
  logic [DATA_W-1:0] rd_data_r;

  // Write port
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // Registered read port
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

### rtl/iea_ctrl.sv
// ----------------------------------------------------------------------------
// iea_ctrl
// Sequencer for the element list: bounds checks, tail push/pop, indexed
// get/set, and the one-element-per-cycle shift for insert and remove.
// Holds the length count and the output register.
// ----------------------------------------------------------------------------
module iea_ctrl #(
  parameter int CAPACITY = 256,
  parameter int ELEM_W   = 64,
  parameter int ADDR_W   = 8,
  parameter int CNT_W    = 9
) (
  input  logic                 clk,
  input  logic                 rst_n,
  // input channel
  input  logic                 in_valid,
  output logic                 in_stall,
  input  iea_pkg::opcode_t     in_opcode,
  input  iea_pkg::position_t   in_position,
  input  iea_pkg::elem_port_t  in_element_in,
  // result channel
  output logic                 out_valid,
  input  logic                 out_stall,
  output iea_pkg::status_t     out_status,
  output iea_pkg::elem_port_t  out_element_out,
  output iea_pkg::length_t     out_length,
  // memory
  output logic                 mem_wr_en,
  output logic [ADDR_W-1:0]    mem_wr_addr,
  output logic [ELEM_W-1:0]    mem_wr_data,
  output logic                 mem_rd_en,
  output logic [ADDR_W-1:0]    mem_rd_addr,
  input  logic [ELEM_W-1:0]    mem_rd_data
);

  import iea_pkg::*;

  // Compare width: wide enough for the count and for a 9-bit length
  localparam int CMP_W = (CNT_W > LENGTH_W) ? CNT_W : LENGTH_W;

  localparam logic [2:0] S_IDLE     = 3'd0;
  localparam logic [2:0] S_READ     = 3'd1;
  localparam logic [2:0] S_SHIFT    = 3'd2;
  localparam logic [2:0] S_INS_LAST = 3'd3;
  localparam logic [2:0] S_RESP     = 3'd4;

  logic [2:0]        state_r,  state_nxt;
  logic [CNT_W-1:0]  count_r,  count_nxt;
  logic [CNT_W-1:0]  idx_r,    idx_nxt;
  logic [CNT_W-1:0]  pos_r,    pos_nxt;
  opcode_t           op_r,     op_nxt;
  logic [ELEM_W-1:0] word_r,   word_nxt;
  status_t           status_r, status_nxt;
  logic [ELEM_W-1:0] elem_r,   elem_nxt;

  logic              out_valid_r;
  status_t           out_status_r;
  elem_port_t        out_elem_r;
  length_t           out_length_r;
  logic              out_load;

  logic [CMP_W-1:0]  cnt_x;
  logic [CMP_W-1:0]  pos_x;
  logic              full;
  logic [CNT_W:0]    rm_next;

  assign cnt_x   = CMP_W'(count_r);
  assign pos_x   = CMP_W'(in_position);
  assign full    = (cnt_x == CMP_W'(CAPACITY));
  assign rm_next = {1'b0, idx_r} + (CNT_W+1)'(2);

  assign in_stall = (state_r != S_IDLE);

  // Next-state and memory access logic
  always_comb begin
    state_nxt   = state_r;
    count_nxt   = count_r;
    idx_nxt     = idx_r;
    pos_nxt     = pos_r;
    op_nxt      = op_r;
    word_nxt    = word_r;
    status_nxt  = status_r;
    elem_nxt    = elem_r;
    mem_wr_en   = 1'b0;
    mem_wr_addr = idx_r[ADDR_W-1:0];
    mem_wr_data = mem_rd_data;
    mem_rd_en   = 1'b0;
    mem_rd_addr = idx_r[ADDR_W-1:0];
    out_load    = 1'b0;

    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          op_nxt     = in_opcode;
          word_nxt   = in_element_in[ELEM_W-1:0];
          pos_nxt    = pos_x[CNT_W-1:0];
          status_nxt = ST_OK;
          elem_nxt   = '0;
          state_nxt  = S_RESP;
          unique case (in_opcode)
            OP_PUSH: begin
              if (full) begin
                status_nxt = ST_FULL;
              end else begin
                mem_wr_en   = 1'b1;
                mem_wr_addr = count_r[ADDR_W-1:0];
                mem_wr_data = in_element_in[ELEM_W-1:0];
                count_nxt   = count_r + CNT_W'(1);
              end
            end
            OP_POP: begin
              if (count_r == '0) begin
                status_nxt = ST_BOUNDS;
              end else begin
                count_nxt   = count_r - CNT_W'(1);
                mem_rd_en   = 1'b1;
                mem_rd_addr = count_nxt[ADDR_W-1:0];
                state_nxt   = S_READ;
              end
            end
            OP_GET: begin
              if (pos_x >= cnt_x) begin
                status_nxt = ST_BOUNDS;
              end else begin
                mem_rd_en   = 1'b1;
                mem_rd_addr = pos_x[ADDR_W-1:0];
                state_nxt   = S_READ;
              end
            end
            OP_SET: begin
              if (pos_x >= cnt_x) begin
                status_nxt = ST_BOUNDS;
              end else begin
                mem_wr_en   = 1'b1;
                mem_wr_addr = pos_x[ADDR_W-1:0];
                mem_wr_data = in_element_in[ELEM_W-1:0];
              end
            end
            OP_INSERT: begin
              if (pos_x > cnt_x) begin
                status_nxt = ST_BOUNDS;
              end else if (full) begin
                status_nxt = ST_FULL;
              end else if (pos_x == cnt_x) begin
                // insert at the tail is a push
                mem_wr_en   = 1'b1;
                mem_wr_addr = pos_x[ADDR_W-1:0];
                mem_wr_data = in_element_in[ELEM_W-1:0];
                count_nxt   = count_r + CNT_W'(1);
              end else begin
                // move last element up first, walk down toward position
                mem_rd_en   = 1'b1;
                mem_rd_addr = ADDR_W'(count_r - CNT_W'(1));
                idx_nxt     = count_r;
                state_nxt   = S_SHIFT;
              end
            end
            OP_REMOVE: begin
              if (pos_x >= cnt_x) begin
                status_nxt = ST_BOUNDS;
              end else if (pos_x + CMP_W'(1) == cnt_x) begin
                // removing the last element needs no shift
                count_nxt = count_r - CNT_W'(1);
              end else begin
                mem_rd_en   = 1'b1;
                mem_rd_addr = ADDR_W'(pos_x + CMP_W'(1));
                idx_nxt     = pos_x[CNT_W-1:0];
                state_nxt   = S_SHIFT;
              end
            end
            default: begin
              // unused opcode: ok, nothing changes
            end
          endcase
        end
      end

      S_READ: begin
        elem_nxt  = mem_rd_data;
        state_nxt = S_RESP;
      end

      S_SHIFT: begin
        // read data from the previous cycle lands at the current target
        mem_wr_en   = 1'b1;
        mem_wr_addr = idx_r[ADDR_W-1:0];
        mem_wr_data = mem_rd_data;
        if (op_r == OP_INSERT) begin
          if (idx_r - CNT_W'(1) == pos_r) begin
            state_nxt = S_INS_LAST;
          end else begin
            mem_rd_en   = 1'b1;
            mem_rd_addr = ADDR_W'(idx_r - CNT_W'(2));
            idx_nxt     = idx_r - CNT_W'(1);
          end
        end else begin
          if (rm_next >= {1'b0, count_r}) begin
            count_nxt = count_r - CNT_W'(1);
            state_nxt = S_RESP;
          end else begin
            mem_rd_en   = 1'b1;
            mem_rd_addr = ADDR_W'(rm_next);
            idx_nxt     = idx_r + CNT_W'(1);
          end
        end
      end

      S_INS_LAST: begin
        mem_wr_en   = 1'b1;
        mem_wr_addr = pos_r[ADDR_W-1:0];
        mem_wr_data = word_r;
        count_nxt   = count_r + CNT_W'(1);
        state_nxt   = S_RESP;
      end

      S_RESP: begin
        if (!out_valid_r || !out_stall) begin
          out_load  = 1'b1;
          state_nxt = S_IDLE;
        end
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // Control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      count_r <= count_nxt;
      if (out_load) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // Working registers
  always_ff @(posedge clk) begin
    idx_r    <= idx_nxt;
    pos_r    <= pos_nxt;
    op_r     <= op_nxt;
    word_r   <= word_nxt;
    status_r <= status_nxt;
    elem_r   <= elem_nxt;
  end

  // Output register
  always_ff @(posedge clk) begin
    if (out_load) begin
      out_status_r <= status_r;
      out_elem_r   <= ELEM_PORT_W'(elem_r);
      out_length_r <= cnt_x[LENGTH_W-1:0];
    end
  end

  assign out_valid       = out_valid_r;
  assign out_status      = out_status_r;
  assign out_element_out = out_elem_r;
  assign out_length      = out_length_r;

  // Count never passes the capacity
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_x <= CMP_W'(CAPACITY))
    else $error("element count above capacity");

  // Every accepted transaction moves the sequencer out of idle
  a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && !in_stall) |=> (state_r != S_IDLE))
    else $error("accepted transaction produced no work");

  // Shift never reads the entry it writes in the same cycle
  a_shift_no_collide: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_SHIFT && mem_rd_en) |-> (mem_rd_addr != mem_wr_addr))
    else $error("shift read and write hit the same entry");

  // Shift cursor stays at or below the count and below the capacity
  a_shift_cursor: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_SHIFT) |-> (idx_r <= count_r && idx_r < CNT_W'(CAPACITY)))
    else $error("shift cursor out of range");

endmodule

### rtl/indexed_element_array_engine.sv
// ----------------------------------------------------------------------------
// indexed_element_array_engine
// Bounded ordered list of element words with push/pop/get/set/insert/remove.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid/in_stall) carries one operation per transaction:
//   opcode, position and element word. Result channel (out_valid/out_stall)
//   returns exactly one transaction per input: status, element read and the
//   new length. A transaction moves when valid is high and stall is low.
//   Flow: one transaction is in work at a time; in_stall stays high
//   until its result is loaded into the output register. Push, set,
//   failed checks, unused opcodes, insert at the tail and removal of the
//   last element go straight to the result; pop and get first wait for
//   the registered memory read. Insert below the count and remove short
//   of the last element shift one element per cycle through the
//   single-read, single-write element memory.
//   Reset (rst_n low, synchronous) empties the list and drops any pending
//   result; memory contents are not cleared and need no clearing pass.
//   While the receiver stalls, the finished result holds in the output
//   register; the next transaction can be accepted and worked, and its
//   result waits until the output register frees up.
// ----------------------------------------------------------------------------
module indexed_element_array_engine #(
  parameter int CAPACITY      = iea_pkg::DEF_CAPACITY,
  parameter int ELEMENT_WIDTH = iea_pkg::DEF_ELEMENT_WIDTH
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  iea_pkg::opcode_t     in_opcode,
  input  iea_pkg::position_t   in_position,
  input  iea_pkg::elem_port_t  in_element_in,
  output logic                 out_valid,
  input  logic                 out_stall,
  output iea_pkg::status_t     out_status,
  output iea_pkg::elem_port_t  out_element_out,
  output iea_pkg::length_t     out_length
);

  localparam int ADDR_W = $clog2(CAPACITY);
  localparam int CNT_W  = $clog2(CAPACITY + 1);

  logic                     mem_wr_en;
  logic [ADDR_W-1:0]        mem_wr_addr;
  logic [ELEMENT_WIDTH-1:0] mem_wr_data;
  logic                     mem_rd_en;
  logic [ADDR_W-1:0]        mem_rd_addr;
  logic [ELEMENT_WIDTH-1:0] mem_rd_data;

  // Sequencer and length count
  iea_ctrl #(
    .CAPACITY (CAPACITY),
    .ELEM_W   (ELEMENT_WIDTH),
    .ADDR_W   (ADDR_W),
    .CNT_W    (CNT_W)
  ) u_ctrl (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_stall        (in_stall),
    .in_opcode       (in_opcode),
    .in_position     (in_position),
    .in_element_in   (in_element_in),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_status      (out_status),
    .out_element_out (out_element_out),
    .out_length      (out_length),
    .mem_wr_en       (mem_wr_en),
    .mem_wr_addr     (mem_wr_addr),
    .mem_wr_data     (mem_wr_data),
    .mem_rd_en       (mem_rd_en),
    .mem_rd_addr     (mem_rd_addr),
    .mem_rd_data     (mem_rd_data)
  );

  // Element memory
  iea_store #(
    .DEPTH  (CAPACITY),
    .ADDR_W (ADDR_W),
    .DATA_W (ELEMENT_WIDTH)
  ) u_store (
    .clk     (clk),
    .wr_en   (mem_wr_en),
    .wr_addr (mem_wr_addr),
    .wr_data (mem_wr_data),
    .rd_en   (mem_rd_en),
    .rd_addr (mem_rd_addr),
    .rd_data (mem_rd_data)
  );

endmodule

### test/tb.sv
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the indexed element array engine. A directed
// stimulus table covers the empty list, field extremes, every operation and
// the bounds cases. After it come a fill to capacity, the full cases and then
// random traffic in three idle settings, with one long output hold-off. Each
// accepted transaction runs through a local list predictor. Every result is
// compared in order against the expected queue.
// ----------------------------------------------------------------------------
module tb;
  import iea_pkg::*;

  localparam int CAP           = DEF_CAPACITY;
  localparam int CYCLE_LIMIT   = 2_000_000;
  localparam int HOLD_CYCLES   = 400;
  localparam int SETTLE_CYCLES = 300;

  // opcodes the block does not use
  localparam opcode_t OP_SPARE_LO = 3'd6;
  localparam opcode_t OP_SPARE_HI = 3'd7;

  typedef struct packed {
    status_t    status;
    elem_port_t elem;
    length_t    len;
  } list_result_t;

  typedef struct packed {
    opcode_t      op;
    position_t    pos;
    elem_port_t   word;
    bit           typed;
    list_result_t res;
  } stim_row_t;

  localparam list_result_t NO_RESULT = '0;

  logic       clk           = 1'b0;
  logic       rst_n         = 1'b0;
  logic       in_valid      = 1'b0;
  logic       in_stall;
  opcode_t    in_opcode     = OP_PUSH;
  position_t  in_position   = '0;
  elem_port_t in_element_in = '0;
  logic       out_valid;
  logic       out_stall     = 1'b0;
  status_t    out_status;
  elem_port_t out_element_out;
  length_t    out_length;

  // list predictor state
  elem_port_t   list_mem [CAP];
  int           list_len = 0;
  list_result_t pending_results [$];

  stim_row_t    stim_rows [$];
  list_result_t want_res;
  int           target_len    = 16;
  int           send_idle_pct = 25;
  int           recv_idle_pct = 58;
  int           mismatch_count = 0;
  int           cycle_count    = 0;
  int           hold_req_count = 0;
  int           hold_req_seen  = 0;
  int           hold_left      = 0;

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  indexed_element_array_engine uut (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_stall        (in_stall),
    .in_opcode       (in_opcode),
    .in_position     (in_position),
    .in_element_in   (in_element_in),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_status      (out_status),
    .out_element_out (out_element_out),
    .out_length      (out_length)
  );

  function automatic list_result_t pack_result(status_t s, elem_port_t e, length_t l);
    list_result_t r;
    r.status = s;
    r.elem   = e;
    r.len    = l;
    return r;
  endfunction

  // Apply one operation to the local list; returns the result it yields
  task automatic apply_list_op(input opcode_t op, input position_t pos,
                               input elem_port_t word, output list_result_t r);
    int k;
    r = NO_RESULT;
    r.status = ST_OK;
    case (op)
      OP_PUSH: begin
        if (list_len >= CAP) r.status = ST_FULL;
        else begin
          list_mem[list_len] = word;
          list_len++;
        end
      end
      OP_POP: begin
        if (list_len == 0) r.status = ST_BOUNDS;
        else begin
          list_len--;
          r.elem = list_mem[list_len];
        end
      end
      OP_GET: begin
        if (pos >= list_len) r.status = ST_BOUNDS;
        else r.elem = list_mem[pos];
      end
      OP_SET: begin
        if (pos >= list_len) r.status = ST_BOUNDS;
        else list_mem[pos] = word;
      end
      OP_INSERT: begin
        // index check wins over the full check
        if (pos > list_len) r.status = ST_BOUNDS;
        else if (list_len >= CAP) r.status = ST_FULL;
        else begin
          for (k = list_len; k > pos; k--) list_mem[k] = list_mem[k-1];
          list_mem[pos] = word;
          list_len++;
        end
      end
      OP_REMOVE: begin
        if (pos >= list_len) r.status = ST_BOUNDS;
        else begin
          for (k = pos; k + 1 < list_len; k++) list_mem[k] = list_mem[k+1];
          list_len--;
        end
      end
      default: ;
    endcase
    r.len = length_t'(list_len);
  endtask

  function automatic void add_row(opcode_t op, position_t pos, elem_port_t word,
                                  bit typed, status_t s, elem_port_t e, length_t l);
    stim_row_t row;
    row.op    = op;
    row.pos   = pos;
    row.word  = word;
    row.typed = typed;
    row.res   = pack_result(s, e, l);
    stim_rows.push_back(row);
  endfunction

  // Offer one transaction, with random idle cycles ahead of it
  task automatic send_op(input opcode_t op, input position_t pos, input elem_port_t word,
                         input bit typed, input list_result_t typed_res);
    list_result_t r;
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid      <= 1'b1;
    in_opcode     <= op;
    in_position   <= pos;
    in_element_in <= word;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    apply_list_op(op, pos, word, r);
    pending_results.push_back(typed ? typed_res : r);
  endtask

  // Random operation, steered so the length drifts toward target_len
  task automatic send_random_op();
    opcode_t   op;
    position_t pos;
    int        pick;
    int        top;
    pick = $urandom_range(99);
    if (pick < 4) begin
      op = ($urandom_range(1) == 1) ? OP_SPARE_HI : OP_SPARE_LO;
    end else begin
      pick = $urandom_range(99);
      if (list_len < target_len) begin
        if (pick < 30) op = OP_PUSH;
        else if (pick < 55) op = OP_INSERT;
        else if (pick < 70) op = OP_GET;
        else if (pick < 85) op = OP_SET;
        else if (pick < 92) op = OP_POP;
        else op = OP_REMOVE;
      end else begin
        if (pick < 25) op = OP_POP;
        else if (pick < 55) op = OP_REMOVE;
        else if (pick < 70) op = OP_GET;
        else if (pick < 85) op = OP_SET;
        else if (pick < 92) op = OP_PUSH;
        else op = OP_INSERT;
      end
    end
    pos = position_t'($urandom_range(255));
    // mostly in-range indexes, the rest anywhere
    if ($urandom_range(99) < 88) begin
      top = (op == OP_INSERT) ? list_len : list_len - 1;
      if (top > 255) top = 255;
      if (top >= 0) pos = position_t'($urandom_range(top));
    end
    send_op(op, pos, {$urandom, $urandom}, 1'b0, NO_RESULT);
  endtask

  task automatic run_random(input int count);
    for (int n = 0; n < count; n++) begin
      if (n % 40 == 0) begin
        target_len = ($urandom_range(9) == 0) ? $urandom_range(200, CAP) : $urandom_range(1, 40);
      end
      send_random_op();
    end
  endtask

  task automatic wait_for_results();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending_results.size() != 0) @(posedge clk);
  endtask

  // Stimulus
  initial begin
    // empty list: every failing case, spare opcodes
    add_row(OP_POP,      8'd0,   '0, 1'b1, ST_BOUNDS, '0, 9'd0);
    add_row(OP_GET,      8'd0,   '0, 1'b1, ST_BOUNDS, '0, 9'd0);
    add_row(OP_SET,      8'd0,   '1, 1'b1, ST_BOUNDS, '0, 9'd0);
    add_row(OP_REMOVE,   8'd0,   '0, 1'b1, ST_BOUNDS, '0, 9'd0);
    add_row(OP_INSERT,   8'd1,   '1, 1'b1, ST_BOUNDS, '0, 9'd0);
    add_row(OP_SPARE_LO, 8'd0,   '1, 1'b1, ST_OK,     '0, 9'd0);
    add_row(OP_SPARE_HI, 8'd255, '1, 1'b1, ST_OK,     '0, 9'd0);
    // extremes of the element word
    add_row(OP_PUSH,     8'd255, '1, 1'b1, ST_OK, '0, 9'd1);
    add_row(OP_PUSH,     8'd0,   '0, 1'b1, ST_OK, '0, 9'd2);
    add_row(OP_GET,      8'd0,   '0, 1'b1, ST_OK, '1, 9'd2);
    add_row(OP_GET,      8'd1,   '1, 1'b1, ST_OK, '0, 9'd2);
    add_row(OP_GET,      8'd2,   '0, 1'b1, ST_BOUNDS, '0, 9'd2);
    // insert at head, at the end (push-like) and in the middle
    add_row(OP_INSERT,   8'd0, 64'hA5A5_A5A5_A5A5_A5A5, 1'b1, ST_OK, '0, 9'd3);
    add_row(OP_INSERT,   8'd3, 64'h5A5A_5A5A_5A5A_5A5A, 1'b1, ST_OK, '0, 9'd4);
    add_row(OP_INSERT,   8'd2, 64'h0123_4567_89AB_CDEF, 1'b0, ST_OK, '0, 9'd0);
    add_row(OP_SET,      8'd4, 64'h8000_0000_0000_0001, 1'b0, ST_OK, '0, 9'd0);
    add_row(OP_GET,      8'd0, '0, 1'b0, ST_OK, '0, 9'd0);
    add_row(OP_REMOVE,   8'd0, '0, 1'b0, ST_OK, '0, 9'd0);
    add_row(OP_GET,      8'd0, '0, 1'b0, ST_OK, '0, 9'd0);
    // remove of the last element, pop, out-of-range get and remove
    add_row(OP_REMOVE,   8'd3,   '0, 1'b0, ST_OK, '0, 9'd0);
    add_row(OP_POP,      8'd0,   '1, 1'b1, ST_OK, '0, 9'd2);
    add_row(OP_GET,      8'd255, '0, 1'b1, ST_BOUNDS, '0, 9'd2);
    add_row(OP_REMOVE,   8'd2,   '0, 1'b1, ST_BOUNDS, '0, 9'd2);
    add_row(OP_POP,      8'd0,   '0, 1'b0, ST_OK, '0, 9'd0);
    add_row(OP_POP,      8'd0,   '0, 1'b1, ST_OK, '1, 9'd0);

    repeat (10) @(posedge clk);
    rst_n <= 1'b1;

    // phase 1: sender idles 25%, receiver 58%
    for (int r = 0; r < stim_rows.size(); r++) begin
      send_op(stim_rows[r].op, stim_rows[r].pos, stim_rows[r].word,
              stim_rows[r].typed, stim_rows[r].res);
    end

    // fill to capacity with pushes and inserts
    while (list_len < CAP) begin
      if ($urandom_range(3) == 0) begin
        send_op(OP_INSERT, position_t'($urandom_range(list_len > 255 ? 255 : list_len)),
                {$urandom, $urandom}, 1'b0, NO_RESULT);
      end else begin
        send_op(OP_PUSH, position_t'($urandom_range(255)), {$urandom, $urandom},
                1'b0, NO_RESULT);
      end
    end

    // full list: push and insert refused, top index reachable, worst shifts
    send_op(OP_PUSH,   8'd0,   '1, 1'b1, pack_result(ST_FULL, '0, length_t'(CAP)));
    send_op(OP_INSERT, 8'd0,   '1, 1'b1, pack_result(ST_FULL, '0, length_t'(CAP)));
    send_op(OP_INSERT, 8'd255, '0, 1'b1, pack_result(ST_FULL, '0, length_t'(CAP)));
    send_op(OP_GET,    8'd255, '0, 1'b0, NO_RESULT);
    send_op(OP_SET,    8'd255, {$urandom, $urandom}, 1'b0, NO_RESULT);
    send_op(OP_GET,    8'd255, '0, 1'b0, NO_RESULT);
    send_op(OP_REMOVE, 8'd0,   '0, 1'b0, NO_RESULT);
    send_op(OP_INSERT, 8'd0,   {$urandom, $urandom}, 1'b0, NO_RESULT);
    send_op(OP_POP,    8'd0,   '0, 1'b0, NO_RESULT);

    run_random(200);
    wait_for_results();

    // phase 2: roles swapped
    send_idle_pct = 58;
    recv_idle_pct = 25;
    run_random(200);
    wait_for_results();

    // phase 3: no idling; one long output hold-off while input keeps coming
    send_idle_pct = 0;
    recv_idle_pct = 0;
    run_random(60);
    hold_req_count++;
    run_random(150);

    wait_for_results();
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (mismatch_count == 0) $display("tb: PASS");
    else $display("tb: FAIL");
    $finish;
  end

  // Result side: stall pattern, hold-off, and in-order checking
  always @(posedge clk) begin
    if (hold_left > 0) begin
      out_stall <= 1'b1;
      hold_left <= hold_left - 1;
    end else if (hold_req_count != hold_req_seen) begin
      hold_req_seen <= hold_req_count;
      hold_left     <= HOLD_CYCLES;
      out_stall     <= 1'b1;
    end else begin
      out_stall <= ($urandom_range(99) < recv_idle_pct);
    end

    if (rst_n && out_valid && !out_stall) begin
      if (pending_results.size() == 0) begin
        if (mismatch_count < 10) begin
          $display("unexpected result: status %0d element %h length %0d",
                   out_status, out_element_out, out_length);
        end
        mismatch_count++;
      end else begin
        want_res = pending_results.pop_front();
        if (out_status !== want_res.status || out_element_out !== want_res.elem ||
            out_length !== want_res.len) begin
          if (mismatch_count < 10) begin
            $display("mismatch: expected status %0d element %h length %0d",
                     want_res.status, want_res.elem, want_res.len);
            $display("          got      status %0d element %h length %0d",
                     out_status, out_element_out, out_length);
          end
          mismatch_count++;
        end
      end
    end
  end

  // Watchdog
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("tb: FAIL");
      $finish;
    end
  end

endmodule
